### sv/ngfe_pkg.sv
package ngfe_pkg;

    localparam int FRAC_DIGITS = 5;
    localparam int FRAC_W      = 3;
    localparam int ACC_W       = 32;
    localparam int SUM_W       = ACC_W + 5;
    localparam int POW_W       = 20;
    localparam int HDR_LEN     = 6;
    localparam int TIME_DIGITS = 6;
    localparam int FCC_W       = 5;

    localparam logic [4:0] HOUR_SHIFT_RESET = 5'd5;
    localparam logic [5:0] HOURS_PER_DAY    = 6'd24;
    localparam logic [7:0] MAX_MIN_SEC      = 8'd59;
    localparam logic [FCC_W-1:0] FCC_MAX    = '1;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;

    localparam logic [7:0] HDR [0:HDR_LEN-1] = '{8'h24, 8'h47, 8'h4E, 8'h47, 8'h47, 8'h41};

    localparam logic [POW_W-1:0] POW10_TAB [0:6] = '{
        20'd1, 20'd10, 20'd100, 20'd1000, 20'd10000, 20'd100000, 20'd1000000
    };

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_COMMAS = 3'd1,
        PH_TIME   = 3'd2,
        PH_LAT    = 3'd3,
        PH_LONG   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_TIME  = 2'd0,
        KIND_LAT   = 2'd1,
        KIND_LONG  = 2'd2,
        KIND_EMPTY = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [4:0]        local_hour;
        logic [5:0]        minutes;
        logic [5:0]        seconds;
        logic [ACC_W-1:0]  coord_magnitude;
        logic              coord_negative;
    } result_t;

    function automatic logic [4:0] tens_mod24(input logic [3:0] d);
        logic [4:0] r;
        case (d)
            4'd0:    r = 5'd0;
            4'd1:    r = 5'd10;
            4'd2:    r = 5'd20;
            4'd3:    r = 5'd6;
            4'd4:    r = 5'd16;
            4'd5:    r = 5'd2;
            4'd6:    r = 5'd12;
            4'd7:    r = 5'd22;
            4'd8:    r = 5'd8;
            4'd9:    r = 5'd18;
            4'd10:   r = 5'd4;
            4'd11:   r = 5'd14;
            4'd12:   r = 5'd0;
            4'd13:   r = 5'd10;
            4'd14:   r = 5'd20;
            default: r = 5'd6;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] local_hour_of(input logic [3:0] d_hi,
                                                 input logic [3:0] d_lo,
                                                 input logic [4:0] offset);
        logic [5:0] t;
        logic [5:0] h;
        logic [5:0] o;
        logic [5:0] l;
        t = {1'b0, tens_mod24(d_hi)} + {2'b00, d_lo};
        h = (t >= HOURS_PER_DAY) ? t - HOURS_PER_DAY : t;
        o = ({1'b0, offset} >= HOURS_PER_DAY) ? {1'b0, offset} - HOURS_PER_DAY
                                                : {1'b0, offset};
        l = h + HOURS_PER_DAY - o;
        if (l >= HOURS_PER_DAY) begin
            l = l - HOURS_PER_DAY;
        end
        return l[4:0];
    endfunction

    function automatic logic [5:0] min_sec_of(input logic [3:0] d_hi,
                                              input logic [3:0] d_lo);
        logic [7:0] v;
        v = {1'b0, d_hi, 3'b000} + {3'b000, d_hi, 1'b0} + {4'b0000, d_lo};
        return (v > MAX_MIN_SEC) ? MAX_MIN_SEC[5:0] : v[5:0];
    endfunction

    function automatic logic [ACC_W-1:0] sat_acc(input logic [SUM_W-1:0] v);
        return (v[SUM_W-1:ACC_W] != '0) ? '1 : v[ACC_W-1:0];
    endfunction

endpackage

### sv/ngfe_in_stage.sv
module ngfe_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] rx_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_ready = !valid_reg || take;

    always_comb begin
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign rx_byte    = byte_reg;

endmodule

### sv/ngfe_parser.sv
module ngfe_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_valid,
    input  logic [7:0]        rx_byte,
    input  logic              out_free,
    input  logic [4:0]        hour_shift,
    output logic              take,
    output logic              load,
    output ngfe_pkg::result_t result
);

    import ngfe_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [2:0]         hp_reg, hp_next;
    logic [2:0]         comma_reg, comma_next;
    logic [FCC_W-1:0]   fcc_reg, fcc_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [FRAC_W-1:0]  fdc_reg, fdc_next;
    logic               point_reg, point_next;
    logic               minus_reg, minus_next;
    logic [3:0]         td_reg [0:TIME_DIGITS-1];

    logic               is_comma, is_minus, is_point;
    logic               hdr_match;
    logic [2:0]         comma_inc;
    logic [FCC_W-1:0]   fcc_bump;
    logic [FRAC_W-1:0]  fdc_inc;
    logic [POW_W+3:0]   int_term, frac_term;
    logic [SUM_W-1:0]   int_sum, frac_sum;
    logic               emit;
    logic               td_we;
    result_t            res;

    assign is_comma  = (rx_byte == CH_COMMA);
    assign is_minus  = (rx_byte == CH_MINUS);
    assign is_point  = (rx_byte == CH_POINT);
    assign hdr_match = (hp_reg < 3'(HDR_LEN)) && (rx_byte == HDR[hp_reg]);
    assign comma_inc = comma_reg + 3'd1;
    assign fcc_bump  = (fcc_reg == FCC_MAX) ? fcc_reg : fcc_reg + 5'd1;
    assign fdc_inc   = fdc_reg + 3'd1;

    assign int_term  = {{POW_W{1'b0}}, rx_byte[3:0]}
                     * {4'b0000, POW10_TAB[FRAC_DIGITS]};
    assign frac_term = {{POW_W{1'b0}}, rx_byte[3:0]}
                     * {4'b0000, POW10_TAB[3'(FRAC_DIGITS) - fdc_inc]};

    assign int_sum  = {2'b00, acc_reg, 3'b000} + {4'b0000, acc_reg, 1'b0}
                    + SUM_W'(int_term);
    assign frac_sum = {5'b00000, acc_reg} + SUM_W'(frac_term);

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_COMMAS: begin
                if (is_comma) begin
                    if (comma_inc == 3'd1) begin
                        phase_next = PH_TIME;
                    end else if (comma_inc == 3'd2) begin
                        phase_next = PH_LAT;
                    end else if (comma_inc == 3'd4) begin
                        phase_next = PH_LONG;
                    end
                end else begin
                    if (comma_reg == 3'd1) begin
                        phase_next = PH_TIME;
                    end else if (comma_reg == 3'd2) begin
                        phase_next = PH_LAT;
                    end else if (comma_reg == 3'd4) begin
                        phase_next = PH_LONG;
                    end
                end
            end
            PH_TIME: begin
                if (is_comma) begin
                    phase_next = PH_LAT;
                end
            end
            PH_LAT: begin
                if (is_comma) begin
                    phase_next = PH_COMMAS;
                end
            end
            PH_LONG: begin
                if (is_comma) begin
                    phase_next = PH_HUNT;
                end
            end
            default: begin
                if (hdr_match && hp_reg == 3'(HDR_LEN - 1)) begin
                    phase_next = PH_COMMAS;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    always_comb begin
        hp_next    = hp_reg;
        comma_next = comma_reg;
        fcc_next   = fcc_reg;
        acc_next   = acc_reg;
        fdc_next   = fdc_reg;
        point_next = point_reg;
        minus_next = minus_reg;
        emit       = 1'b0;
        td_we      = 1'b0;
        res        = '0;
        unique case (phase_reg)
            PH_COMMAS: begin
                if (is_comma) begin
                    comma_next = comma_inc;
                end
            end
            PH_TIME: begin
                if (!is_comma) begin
                    fcc_next = fcc_bump;
                    td_we    = (fcc_reg < 5'(TIME_DIGITS));
                end else begin
                    comma_next = comma_inc;
                    emit       = 1'b1;
                    if (fcc_reg == '0) begin
                        res.kind = KIND_EMPTY;
                    end else begin
                        res.kind       = KIND_TIME;
                        res.local_hour = local_hour_of(td_reg[0], td_reg[1], hour_shift);
                        res.minutes    = min_sec_of(td_reg[2], td_reg[3]);
                        res.seconds    = min_sec_of(td_reg[4], td_reg[5]);
                    end
                    fcc_next   = '0;
                    acc_next   = '0;
                    fdc_next   = '0;
                    point_next = 1'b0;
                    minus_next = 1'b0;
                end
            end
            PH_LAT, PH_LONG: begin
                if (is_comma) begin
                    emit = 1'b1;
                    if (fcc_reg == '0) begin
                        res.kind = KIND_EMPTY;
                    end else begin
                        res.kind            = (phase_reg == PH_LAT) ? KIND_LAT : KIND_LONG;
                        res.coord_magnitude = acc_reg;
                        res.coord_negative  = minus_reg && (acc_reg != '0);
                    end
                    if (phase_reg == PH_LAT) begin
                        comma_next = comma_inc;
                    end else begin
                        comma_next = '0;
                        hp_next    = '0;
                    end
                    fcc_next   = '0;
                    acc_next   = '0;
                    fdc_next   = '0;
                    point_next = 1'b0;
                    minus_next = 1'b0;
                end else if (is_minus) begin
                    minus_next = 1'b1;
                end else if (is_point) begin
                    fcc_next   = fcc_bump;
                    point_next = 1'b1;
                end else begin
                    fcc_next = fcc_bump;
                    if (!point_reg) begin
                        acc_next = sat_acc(int_sum);
                    end else if (fdc_reg < 3'(FRAC_DIGITS)) begin
                        fdc_next = fdc_inc;
                        acc_next = sat_acc(frac_sum);
                    end
                end
            end
            default: begin
                if (hdr_match) begin
                    if (hp_reg == 3'(HDR_LEN - 1)) begin
                        hp_next    = '0;
                        comma_next = '0;
                        fcc_next   = '0;
                        acc_next   = '0;
                        fdc_next   = '0;
                        point_next = 1'b0;
                        minus_next = 1'b0;
                    end else begin
                        hp_next = hp_reg + 3'd1;
                    end
                end else begin
                    hp_next = '0;
                end
            end
        endcase
    end

    assign take   = byte_valid && (!emit || out_free);
    assign load   = take && emit;
    assign result = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            hp_reg    <= '0;
            comma_reg <= '0;
            fcc_reg   <= '0;
            acc_reg   <= '0;
            fdc_reg   <= '0;
            point_reg <= 1'b0;
            minus_reg <= 1'b0;
        end else if (take) begin
            phase_reg <= phase_next;
            hp_reg    <= hp_next;
            comma_reg <= comma_next;
            fcc_reg   <= fcc_next;
            acc_reg   <= acc_next;
            fdc_reg   <= fdc_next;
            point_reg <= point_next;
            minus_reg <= minus_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && td_we) begin
            td_reg[fcc_reg[2:0]] <= rx_byte[3:0];
        end
    end

endmodule

### sv/ngfe_out_stage.sv
module ngfe_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  ngfe_pkg::result_t result,
    output logic              out_free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_result_kind,
    output logic [4:0]        m_local_hour,
    output logic [5:0]        m_minutes,
    output logic [5:0]        m_seconds,
    output logic [31:0]       m_coord_magnitude,
    output logic              m_coord_negative
);

    import ngfe_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= result;
        end
    end

    assign m_valid           = valid_reg;
    assign m_result_kind     = res_reg.kind;
    assign m_local_hour      = res_reg.local_hour;
    assign m_minutes         = res_reg.minutes;
    assign m_seconds         = res_reg.seconds;
    assign m_coord_magnitude = res_reg.coord_magnitude;
    assign m_coord_negative  = res_reg.coord_negative;

endmodule

### sv/nmea_gga_field_extractor.sv
// Path: a byte accepted on s_valid is held in the input register; a byte that closes
// a field then has its result registered in the result register and shown on m_valid.
// Throughput: one byte per cycle; the parser state register advances once per byte,
// and a byte that closes a field waits only while a result is held on m_valid.
// Reset: aresetn is synchronous, active low; it restarts the header hunt,
// clears all counters and the accumulator, and sets the UTC offset to 5.
module nmea_gga_field_extractor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [4:0]  m_local_hour,
    output logic [5:0]  m_minutes,
    output logic [5:0]  m_seconds,
    output logic [31:0] m_coord_magnitude,
    output logic        m_coord_negative
);

    import ngfe_pkg::*;

    logic       cfg_we;
    logic [4:0] hour_shift_reg;
    logic       byte_valid;
    logic [7:0] rx_byte;
    logic       take;
    logic       load;
    logic       out_free;
    result_t    result;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hour_shift_reg <= HOUR_SHIFT_RESET;
        end else if (cfg_we) begin
            hour_shift_reg <= cfg_data;
        end
    end

    ngfe_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .take       (take),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte)
    );

    ngfe_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte),
        .out_free   (out_free),
        .hour_shift (hour_shift_reg),
        .take       (take),
        .load       (load),
        .result     (result)
    );

    ngfe_out_stage u_out_stage (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .load              (load),
        .result            (result),
        .out_free          (out_free),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_local_hour      (m_local_hour),
        .m_minutes         (m_minutes),
        .m_seconds         (m_seconds),
        .m_coord_magnitude (m_coord_magnitude),
        .m_coord_negative  (m_coord_negative)
    );

endmodule

### tb/gga_result_checker.sv
module gga_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_result_kind,
    input  logic [4:0]  m_local_hour,
    input  logic [5:0]  m_minutes,
    input  logic [5:0]  m_seconds,
    input  logic [31:0] m_coord_magnitude,
    input  logic        m_coord_negative,
    output int          mismatches,
    output int          outstanding
);

    import ngfe_pkg::*;

    localparam logic [47:0] GGA_TAG = "$GNGGA";

    phase_t      phase;
    logic [2:0]  tag_pos;
    logic [2:0]  comma_cnt;
    logic [4:0]  char_cnt;
    logic [7:0]  time_chars [0:5];
    logic [31:0] coord_acc;
    logic [2:0]  frac_cnt;
    logic        point_seen;
    logic        minus_seen;
    logic [4:0]  hour_shift;

    result_t     expected_fields [$];
    result_t     fresh;
    result_t     seen;
    result_t     want;
    bit          produced;
    int          bad_count = 0;

    assign mismatches = bad_count;

    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        p = 64'd1;
        repeat (n) p = p * 64'd10;
        return p;
    endfunction

    function automatic int pair_of(input int i);
        return time_chars[i][3:0] * 10 + time_chars[i+1][3:0];
    endfunction

    task automatic clear_field();
        char_cnt   = '0;
        coord_acc  = '0;
        frac_cnt   = '0;
        point_seen = 1'b0;
        minus_seen = 1'b0;
    endtask

    task automatic count_char();
        if (char_cnt != 5'd31) char_cnt++;
    endtask

    task automatic coord_char(input logic [7:0] ch);
        logic [63:0] sum;
        sum = {32'd0, coord_acc};
        if (ch == CH_MINUS) begin
            minus_seen = 1'b1;
        end else if (ch == CH_POINT) begin
            count_char();
            point_seen = 1'b1;
        end else begin
            count_char();
            if (!point_seen) begin
                sum = sum * 64'd10 + {60'd0, ch[3:0]} * pow10(FRAC_DIGITS);
            end else if (frac_cnt < FRAC_DIGITS) begin
                frac_cnt++;
                sum = sum + {60'd0, ch[3:0]} * pow10(FRAC_DIGITS - frac_cnt);
            end
            coord_acc = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        end
    endtask

    task automatic close_coord(input kind_t k, output result_t r);
        r = '0;
        if (char_cnt == 5'd0) begin
            r.kind = KIND_EMPTY;
        end else begin
            r.kind            = k;
            r.coord_magnitude = coord_acc;
            r.coord_negative  = minus_seen && (coord_acc != 32'd0);
        end
        clear_field();
    endtask

    task automatic parse_gga_byte(input logic [7:0] ch, output bit emit, output result_t r);
        int hh;
        int mm;
        int ss;
        emit = 1'b0;
        r    = '0;
        case (phase)
            PH_COMMAS: begin
                if (ch == CH_COMMA) comma_cnt++;
                if (comma_cnt == 3'd1) phase = PH_TIME;
                else if (comma_cnt == 3'd2) phase = PH_LAT;
                else if (comma_cnt == 3'd4) phase = PH_LONG;
            end
            PH_TIME: begin
                if (ch != CH_COMMA) begin
                    if (char_cnt < 5'd6) time_chars[char_cnt] = ch;
                    count_char();
                end else begin
                    comma_cnt++;
                    phase = PH_LAT;
                    emit  = 1'b1;
                    if (char_cnt == 5'd0) begin
                        r.kind = KIND_EMPTY;
                    end else begin
                        hh = pair_of(0) % 24;
                        mm = pair_of(2);
                        ss = pair_of(4);
                        r.kind       = KIND_TIME;
                        r.local_hour = 5'((hh + 24 - (hour_shift % 24)) % 24);
                        r.minutes    = 6'((mm > 59) ? 59 : mm);
                        r.seconds    = 6'((ss > 59) ? 59 : ss);
                    end
                    clear_field();
                end
            end
            PH_LAT: begin
                if (ch != CH_COMMA) begin
                    coord_char(ch);
                end else begin
                    comma_cnt++;
                    phase = PH_COMMAS;
                    emit  = 1'b1;
                    close_coord(KIND_LAT, r);
                end
            end
            PH_LONG: begin
                if (ch != CH_COMMA) begin
                    coord_char(ch);
                end else begin
                    comma_cnt = '0;
                    tag_pos   = '0;
                    phase     = PH_HUNT;
                    emit      = 1'b1;
                    close_coord(KIND_LONG, r);
                end
            end
            default: begin
                if (tag_pos < 3'd6 && ch == GGA_TAG[47 - 8*tag_pos -: 8]) begin
                    tag_pos++;
                    if (tag_pos == 3'd6) begin
                        tag_pos   = '0;
                        comma_cnt = '0;
                        clear_field();
                        phase = PH_COMMAS;
                    end
                end else begin
                    tag_pos = '0;
                    phase   = PH_HUNT;
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase      = PH_HUNT;
            tag_pos    = '0;
            comma_cnt  = '0;
            hour_shift = HOUR_SHIFT_RESET;
            foreach (time_chars[i]) time_chars[i] = 8'h00;
            clear_field();
            expected_fields.delete();
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) hour_shift = cfg_data;
            if (m_valid && m_ready) begin
                seen = {m_result_kind, m_local_hour, m_minutes, m_seconds,
                        m_coord_magnitude, m_coord_negative};
                if (expected_fields.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display({"%0t: unexpected result kind %0d hour %0d min %0d",
                                  " sec %0d mag %0d neg %0d"},
                                 $time, seen.kind, seen.local_hour, seen.minutes,
                                 seen.seconds, seen.coord_magnitude, seen.coord_negative);
                end else begin
                    want = expected_fields.pop_front();
                    if (seen !== want) begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display({"%0t: mismatch expected kind %0d hour %0d min %0d sec %0d",
                                      " mag %0d neg %0d, got kind %0d hour %0d min %0d sec %0d",
                                      " mag %0d neg %0d"},
                                     $time, want.kind, want.local_hour, want.minutes,
                                     want.seconds, want.coord_magnitude, want.coord_negative,
                                     seen.kind, seen.local_hour, seen.minutes, seen.seconds,
                                     seen.coord_magnitude, seen.coord_negative);
                    end
                end
            end
            if (s_valid && s_ready) begin
                parse_gga_byte(s_rx_byte, produced, fresh);
                if (produced) expected_fields.push_back(fresh);
            end
            outstanding <= expected_fields.size();
        end
    end

endmodule

### tb/tb_nmea_gga_field_extractor.sv
module tb_nmea_gga_field_extractor;

    import ngfe_pkg::*;

    localparam int STALL_LEN   = 400;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_BYTES = 140;
    localparam logic [4:0] OFFSET_PLAN [0:5] = '{5'd0, 5'd23, 5'd31, 5'd24, 5'd12, 5'd7};

    typedef enum logic [1:0] {
        RX_ALWAYS = 2'd0,
        RX_MOSTLY = 2'd1,
        RX_RARELY = 2'd2,
        RX_PULSED = 2'd3
    } rx_mode_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [4:0]  cfg_data  = '0;
    logic        s_valid   = 1'b0;
    logic [7:0]  s_rx_byte = '0;
    logic        m_ready   = 1'b0;
    logic        cfg_ready;
    logic        s_ready;
    logic        m_valid;
    logic [1:0]  m_result_kind;
    logic [4:0]  m_local_hour;
    logic [5:0]  m_minutes;
    logic [5:0]  m_seconds;
    logic [31:0] m_coord_magnitude;
    logic        m_coord_negative;

    int          mismatches;
    int          outstanding;
    logic [7:0]  line_buf [$];
    int          burst_left = 0;
    int          sent       = 0;
    int          quiet      = 0;
    int          rx_tick    = 0;
    rx_mode_t    rx_mode    = RX_ALWAYS;
    bit          hold_off   = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    nmea_gga_field_extractor uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_local_hour      (m_local_hour),
        .m_minutes         (m_minutes),
        .m_seconds         (m_seconds),
        .m_coord_magnitude (m_coord_magnitude),
        .m_coord_negative  (m_coord_negative)
    );

    gga_result_checker gga_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_local_hour      (m_local_hour),
        .m_minutes         (m_minutes),
        .m_seconds         (m_seconds),
        .m_coord_magnitude (m_coord_magnitude),
        .m_coord_negative  (m_coord_negative),
        .mismatches        (mismatches),
        .outstanding       (outstanding)
    );

    // receiver: drives m_ready from a randomly chosen stall pattern, or holds off on request
    always begin
        @(posedge aclk);
        if (hold_off) begin
            m_ready <= 1'b0;
            repeat (STALL_LEN) @(posedge aclk);
            hold_off = 1'b0;
        end else begin
            if (rx_tick % 97 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_tick++;
            case (rx_mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                RX_RARELY: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= ((rx_tick / 3) % 2 == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic offer_byte(input logic [7:0] b);
        int r;
        int gap;
        if (burst_left == 0) begin
            r   = $urandom_range(0, 99);
            gap = (r < 40) ? 0 : (r < 80) ? $urandom_range(1, 4) : $urandom_range(5, 30);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 99) < 15) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 16);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
    endtask

    task automatic send_line();
        while (line_buf.size() > 0) begin
            offer_byte(line_buf.pop_front());
            sent++;
        end
    endtask

    // hold input and wait until every result is out and the pipe is empty
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_offset(input logic [4:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic put_text(input string t);
        for (int i = 0; i < t.len(); i++) line_buf.push_back(t[i]);
    endtask

    task automatic put_from(input string set, input int n);
        repeat (n) line_buf.push_back(set[$urandom_range(0, set.len() - 1)]);
    endtask

    task automatic put_digits(input int n);
        put_from("0123456789", n);
    endtask

    task automatic put_any(input int n);
        repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic put_junk(input int n);
        logic [7:0] b;
        repeat (n) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_COMMA);
            line_buf.push_back(b);
        end
    endtask

    task automatic put_time_field();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            put_digits(6);
            if ($urandom_range(0, 1)) begin
                put_text(".");
                put_digits($urandom_range(1, 3));
            end
        end else if (r < 72) begin
            put_digits($urandom_range(7, 14));
        end else if (r < 82) begin
            put_digits($urandom_range(1, 5));
        end else if (r >= 90) begin
            put_junk($urandom_range(1, 10));
        end
    endtask

    task automatic put_coord_field();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            if ($urandom_range(0, 4) == 0) put_text("-");
            put_digits($urandom_range(1, 5));
            if ($urandom_range(0, 6) != 0) begin
                put_text(".");
                put_digits($urandom_range(0, 8));
            end
        end else if (r >= 65 && r < 70) begin
            put_from("-", $urandom_range(1, 3));
        end else if (r >= 70 && r < 78) begin
            put_digits($urandom_range(10, 40));
            if ($urandom_range(0, 1)) begin
                put_text(".");
                put_digits($urandom_range(1, 8));
            end
        end else if (r >= 78 && r < 90) begin
            put_from("0123456789.-", $urandom_range(1, 14));
        end else if (r >= 90) begin
            put_junk($urandom_range(1, 12));
        end
    endtask

    task automatic put_sentence();
        int r;
        put_text("$GNGGA,");
        put_time_field();
        put_text(",");
        put_coord_field();
        put_text(",");
        r = $urandom_range(0, 9);
        if (r < 7) put_from("NS", 1);
        else if (r < 9) put_junk($urandom_range(1, 3));
        put_text(",");
        put_coord_field();
        put_text(",");
        put_from("0123456789.,*MEW", $urandom_range(0, 20));
        if ($urandom_range(0, 1)) begin
            line_buf.push_back(8'h0D);
            line_buf.push_back(8'h0A);
        end
    endtask

    task automatic put_noise();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            put_any($urandom_range(1, 30));
        end else if (r < 70) begin
            k = $urandom_range(1, 5);
            for (int i = 0; i < k; i++) line_buf.push_back(HDR[i]);
            put_any($urandom_range(1, 5));
        end else begin
            put_sentence();
            repeat ($urandom_range(1, 10))
                if (line_buf.size() > 1) line_buf.delete(line_buf.size() - 1);
        end
    endtask

    initial begin
        int phase_start;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // a full time field comes first so every stored time digit is written
        put_text("$GNGGA,235959.00,4807.038,N,-01131.000,E,1*5B");
        put_text("$GNGGA,999999,-0.000,,,");
        put_text("$GNGGA,,,x,,");
        put_text("$G$GNGGA,120000,1,N,1,E,");
        put_text("$GNGG$GNGGA,1,1,N,1,E,");
        put_text("$GNGGA,12,-,N,99999999999.123456789,E,");
        put_text("$GNGGA,0000000000,1.2.3-4,N,A9,E,");
        put_text("$GNGGA,000000,..,N,--5,E,");
        put_text("$GNGGA,000000,42949.67295,N,42949.67296,E,");
        put_text("$GNGGA,235900,000000000000000000000000000000000000001.5,N,0.99999,W,");
        send_line();

        for (int p = 0; p < 6; p++) begin
            settle();
            write_offset((p == 5) ? 5'($urandom_range(0, 23)) : OFFSET_PLAN[p]);
            if (p == 2) hold_off = 1'b1;
            phase_start = sent;
            while (sent - phase_start < PHASE_BYTES) begin
                if ($urandom_range(0, 99) < 85) put_sentence();
                else put_noise();
                send_line();
            end
        end

        settle();
        repeat (4) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
sv/ngfe_pkg.sv
sv/ngfe_in_stage.sv
sv/ngfe_parser.sv
sv/ngfe_out_stage.sv
sv/nmea_gga_field_extractor.sv
tb/gga_result_checker.sv
tb/tb_nmea_gga_field_extractor.sv
